### rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    // Bitmap geometry
    localparam int WORDS         = 256;
    localparam int WORD_BITS     = 32;
    localparam int BIT_W         = 5;
    localparam int GROUP_SIZE    = 16;
    localparam int SUB_W         = 4;
    localparam int GROUPS        = (WORDS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_W         = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int IDX_W         = GRP_W + SUB_W;
    localparam int PAD_WORDS     = GROUPS * GROUP_SIZE;
    localparam int TOTAL_ENTRIES = WORDS * WORD_BITS;

    // Field widths
    localparam int NUM_W    = 16;
    localparam int ENTRY_W  = 13;
    localparam int CNT_W    = 14;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Counter limits
    localparam int CNT_MAX_I = 16383;
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(CNT_MAX_I);
    localparam logic [CNT_W-1:0] CNT_RESET =
        CNT_W'((TOTAL_ENTRIES > CNT_MAX_I) ? CNT_MAX_I : TOTAL_ENTRIES);

    localparam logic [WORD_BITS-1:0] TOP_BIT = 32'h8000_0000;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic grp_sel;
        logic word_sel;
        logic rd;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_free;
        logic in_range_err;
        logic grp_none;
        logic out_ready;
    } dp_stat_t;

    // Lowest index of a clear bit in a group of full flags
    function automatic logic [SUB_W-1:0] first_zero16(input logic [GROUP_SIZE-1:0] v);
        logic [SUB_W-1:0] idx;
        idx = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = SUB_W'(i);
            end
        end
        return idx;
    endfunction

    // Count of leading ones, i.e. the position of the first clear bit from the MSB
    function automatic logic [BIT_W-1:0] lead_ones32(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!v[i]) begin
                idx = BIT_W'(WORD_BITS - 1 - i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### rtl/bitmap_block_allocator.sv
`default_nettype none

// Bitmap allocator over WORDS (256) 32-bit words, 8192 entries. Send one word on the
// s_ side: s_tuser is the opcode (0 allocate first free entry, 1 free the entry in
// s_tdata). Each request returns exactly one m_ word with a status (ok, entry out of
// range, no free entry), the granted entry number and the free counter after the
// request. Allocation picks the lowest word with a clear bit, then the first clear bit
// from the MSB down; entry = word*32 + bit-from-MSB. A free increments the counter even
// if the bit was already clear; the counter saturates at 16383 and at 0. An allocate
// steps through group pick, word pick, memory read and update; an allocate on a full
// map goes from group pick to update, a free from memory read to update, and an
// out-of-range free straight to update; one request is in flight at a time. The input
// reopens the cycle after the result is committed. A new request may be taken while
// the previous result still waits in the output register. No clearing pass: per-word
// valid and full flags reset at once.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] entry_number
    input  wire logic                  s_tuser,   // [0] opcode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // [1:0] status, [14:2] allocated_entry,
                                                  // [28:15] free_count, [31:29] zero
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each request
    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold bitmap, summaries, counter and result
    bba_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/bba_ctrl.sv
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROUP,
        S_WORD,
        S_READ,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!stat.in_free) begin
                        state_next = S_GROUP;
                    end else if (stat.in_range_err) begin
                        state_next = S_COMMIT;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_GROUP:  state_next = stat.grp_none ? S_COMMIT : S_WORD;
            S_WORD:   state_next = S_READ;
            S_READ:   state_next = S_COMMIT;
            S_COMMIT: begin
                if (stat.out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.grp_sel  = (state_reg == S_GROUP);
    assign cmd.word_sel = (state_reg == S_WORD);
    assign cmd.rd       = (state_reg == S_READ);
    assign cmd.commit   = (state_reg == S_COMMIT) && stat.out_ready;

endmodule

`default_nettype wire

### rtl/bba_datapath.sv
`default_nettype none

module bba_datapath
    import bba_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    input  wire logic                   s_tuser,
    input  wire dp_cmd_t                cmd,
    output dp_stat_t                    stat,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata
);

    // Request registers
    logic                 op_reg;
    logic [BIT_W-1:0]     num_reg;
    logic                 range_err_reg;
    logic                 no_free_reg;
    logic [GRP_W-1:0]     grp_reg;
    logic [IDX_W-1:0]     idx_reg;

    // Bitmap memory, per-word valid and full flags
    logic [WORD_BITS-1:0] mem [PAD_WORDS];
    logic [WORD_BITS-1:0] mem_q_reg;
    logic                 vld_q_reg;
    logic [PAD_WORDS-1:0] valid_reg;
    logic [PAD_WORDS-1:0] full_reg;

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    // Result register
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [ENTRY_W-1:0]   m_entry_reg;
    logic [CNT_W-1:0]     m_count_reg;

    logic [31:0]          in_num_ext;
    logic [GROUPS-1:0]    grp_free;
    logic [GRP_W-1:0]     grp_first;
    logic [GROUP_SIZE-1:0] grp_bits;
    logic [WORD_BITS-1:0] word;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     bit_sel;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] new_word;
    logic                 do_write;
    logic [STATUS_W-1:0]  status_next;
    logic [ENTRY_W-1:0]   entry_next;

    assign in_num_ext = 32'(s_tdata[NUM_W-1:0]);

    // Group summary: a group has room when any of its words is not full
    always_comb begin
        grp_first = '0;
        for (int g = 0; g < GROUPS; g++) begin
            grp_free[g] = ~&full_reg[g*GROUP_SIZE +: GROUP_SIZE];
        end
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_free[g]) begin
                grp_first = GRP_W'(g);
            end
        end
    end

    assign grp_bits = full_reg[grp_reg*GROUP_SIZE +: GROUP_SIZE];

    assign stat.in_free      = (s_tuser == OP_FREE);
    assign stat.in_range_err = (in_num_ext >= 32'(TOTAL_ENTRIES));
    assign stat.grp_none     = ~|grp_free;
    assign stat.out_ready    = !m_valid_reg || m_tready;

    // Commit: modify the fetched word
    assign word     = vld_q_reg ? mem_q_reg : '0;
    assign lo_bit   = lead_ones32(word);
    assign bit_sel  = op_reg ? num_reg : lo_bit;
    assign mask     = TOP_BIT >> bit_sel;
    assign new_word = op_reg ? (word & ~mask) : (word | mask);
    assign do_write = cmd.commit && !range_err_reg && !no_free_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_write) begin
            if (op_reg == OP_FREE) begin
                if (cnt_reg != CNT_MAX) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end else if (cnt_reg != '0) begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_comb begin
        priority if (range_err_reg) begin
            status_next = ST_RANGE;
        end else if (no_free_reg) begin
            status_next = ST_FULL;
        end else begin
            status_next = ST_OK;
        end
    end

    assign entry_next = (op_reg == OP_ALLOC && do_write) ? ENTRY_W'({idx_reg, lo_bit}) : '0;

    // Request decode and word selection
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= s_tuser;
            num_reg       <= s_tdata[BIT_W-1:0];
            range_err_reg <= stat.in_free && stat.in_range_err;
            no_free_reg   <= 1'b0;
            idx_reg       <= in_num_ext[BIT_W +: IDX_W];
        end
        if (cmd.grp_sel) begin
            grp_reg     <= grp_first;
            no_free_reg <= stat.grp_none;
        end
        if (cmd.word_sel) begin
            idx_reg <= {grp_reg, first_zero16(grp_bits)};
        end
    end

    // Memory port: one read, one write
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            mem_q_reg <= mem[idx_reg];
            vld_q_reg <= valid_reg[idx_reg];
        end
        if (do_write) begin
            mem[idx_reg] <= new_word;
        end
    end

    // Flags, counter and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            for (int i = 0; i < PAD_WORDS; i++) begin
                full_reg[i] <= (i >= WORDS);
            end
            cnt_reg     <= CNT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (do_write) begin
                valid_reg[idx_reg] <= 1'b1;
                full_reg[idx_reg]  <= &new_word;
            end
            cnt_reg <= cnt_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg <= status_next;
            m_entry_reg  <= entry_next;
            m_count_reg  <= cnt_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({m_count_reg, m_entry_reg, m_status_reg});

    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_ready)
        else $error("commit while result register occupied");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_alloc_has_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && op_reg == OP_ALLOC && !no_free_reg) |-> (!vld_q_reg || mem_q_reg != '1))
        else $error("allocate picked a full word");

    a_group_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.word_sel |-> !(&grp_bits))
        else $error("word select in a full group");

endmodule

`default_nettype wire
